### hdl/page_aware_packet_splitter_defines.svh
// Assertion macros used by the checker file.
`ifndef PAGE_AWARE_PACKET_SPLITTER_DEFINES_SVH
`define PAGE_AWARE_PACKET_SPLITTER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PGSPLIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PGSPLIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pgsplit_pkg.sv
`default_nettype none
package pgsplit_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned LEN_W     = 12;
  localparam int unsigned PAGE_W    = 17;
  localparam int unsigned PKT_W     = 12;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned PNUM_W    = 25;
  localparam int unsigned OFF_W     = 11;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [PAGE_W-1:0] PAGE_MAX = 17'd65536;
  localparam logic [PKT_W-1:0]  PKT_MIN  = 12'd128;
  localparam logic [PKT_W-1:0]  PKT_MAX  = 12'd2048;
  localparam logic [IDX_W-1:0]  IDX_LAST = 6'd63;

  localparam logic CFG_PAGE_SIZE   = 1'b0;
  localparam logic CFG_PACKET_SIZE = 1'b1;

  typedef struct packed {
    logic              err;
    logic              paged;
    logic [ADDR_W-1:0] addr;
    logic [PNUM_W-1:0] page;
    logic [PAGE_W-1:0] inpage;
    logic [LEN_W-1:0]  total;
    logic [PKT_W-1:0]  pkt;
    logic [PAGE_W-1:0] pg;
  } pgsplit_job_t;

endpackage
`default_nettype wire

### hdl/page_aware_packet_splitter.sv
// Page-aware packet splitter.
// Slave stream: one descriptor per word (base address, byte length).
// Master stream: one word per packet; tlast marks the last packet of a
// descriptor, tuser flags the single error word sent when the page size is
// nonzero and below the packet size, even for zero length; other zero-length
// descriptors yield nothing. Config: cfg_we_i/cfg_idx_i/cfg_wdata_i, index 0
// page size, 1 packet size, to be written only while the block is idle;
// the block does not enforce this. Front: takes a descriptor, then runs
// a bit-serial divider for the page number and page offset (skipped when
// unpaged), then pushes the job into a two-deep descriptor queue, waiting
// while the queue is full; it takes no new descriptor until that push.
// Back: loads a job, then moves one packet per cycle into the output
// register while that register is empty or being taken by the receiver.
// A stalled receiver holds the output word; while the back is stalled the
// queue takes two more descriptors and the front one after that, then
// tready stays low.
// Reset clears the handshake state and loads page size 0, packet size 128.
`default_nettype none
module page_aware_packet_splitter import pgsplit_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 2048
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // base_address[31:0], total_length[43:32], zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // packet_index[5:0], page_number[30:6], address_in_page[62:31],
  // byte_offset[73:63], packet_length[85:74], zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                       m_axis_tlast_o,
  // config_error[0]
  output logic                       m_axis_tuser_o
);

  pgsplit_job_t push_job, pop_job;
  logic push, full, pop, empty;
  logic [IDX_W-1:0]  o_idx;
  logic [PNUM_W-1:0] o_page;
  logic [ADDR_W-1:0] o_addr;
  logic [OFF_W-1:0]  o_off;
  logic [LEN_W-1:0]  o_len;

  pgsplit_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_base_i   (s_axis_tdata_i[31:0]),
    .in_total_i  (s_axis_tdata_i[43:32]),
    .push_o      (push),
    .full_i      (full),
    .job_o       (push_job)
  );

  pgsplit_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (push_job),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .rd_data_o (pop_job)
  );

  pgsplit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_idx_o   (o_idx),
    .out_page_o  (o_page),
    .out_addr_o  (o_addr),
    .out_off_o   (o_off),
    .out_len_o   (o_len),
    .out_last_o  (m_axis_tlast_o),
    .out_err_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, o_len, o_off, o_addr, o_page, o_idx};

endmodule
`default_nettype wire

### hdl/pgsplit_front.sv
`default_nettype none
module pgsplit_front import pgsplit_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 2048
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ADDR_W-1:0] in_base_i,
  input  wire logic [LEN_W-1:0]  in_total_i,
  output logic                   push_o,
  input  wire logic              full_i,
  output pgsplit_job_t           job_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } pgsplit_fstate_e;

  pgsplit_fstate_e state_q, state_d;
  logic [PAGE_W-1:0] page_size_q, page_size_d;
  logic [PKT_W-1:0]  packet_size_q, packet_size_d;
  pgsplit_job_t      job_q, job_d;
  logic [PAGE_W-1:0] rem_q, rem_d;
  logic [ADDR_W-1:0] quo_q, quo_d;
  logic [4:0]        cnt_q, cnt_d;

  logic [PAGE_W-1:0] pg_c;
  logic [PKT_W-1:0]  pkt_c;
  logic [LEN_W-1:0]  len_c;
  logic              err_c;
  logic [PAGE_W:0]   rem_sh;
  logic              ge;

  always_comb begin
    pg_c  = (page_size_q > PAGE_MAX) ? PAGE_MAX : page_size_q;
    pkt_c = (packet_size_q < PKT_MIN) ? PKT_MIN :
            ((packet_size_q > PKT_MAX) ? PKT_MAX : packet_size_q);
    len_c = ({20'd0, in_total_i} > 32'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : in_total_i;
    err_c = (pg_c != '0) && (pg_c < {5'd0, pkt_c});
    rem_sh = {rem_q, quo_q[ADDR_W-1]};
    ge     = rem_sh >= {1'b0, job_q.pg};
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign job_o      = job_q;

  always_comb begin
    state_d       = state_q;
    page_size_d   = page_size_q;
    packet_size_d = packet_size_q;
    job_d         = job_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    cnt_d         = cnt_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAGE_SIZE:   page_size_d   = cfg_wdata_i;
        CFG_PACKET_SIZE: packet_size_d = cfg_wdata_i[PKT_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          job_d.err    = err_c;
          job_d.paged  = (pg_c != '0);
          job_d.addr   = in_base_i;
          job_d.page   = '0;
          job_d.inpage = '0;
          job_d.total  = len_c;
          job_d.pkt    = pkt_c;
          job_d.pg     = pg_c;
          rem_d        = '0;
          quo_d        = in_base_i;
          cnt_d        = '0;
          if (err_c) begin
            state_d = F_PUSH;
          end else if (len_c == '0) begin
            state_d = F_IDLE;
          end else if (pg_c != '0) begin
            state_d = F_DIV;
          end else begin
            state_d = F_PUSH;
          end
        end
      end
      F_DIV: begin
        rem_d = ge ? PAGE_W'(rem_sh - {1'b0, job_q.pg}) : rem_sh[PAGE_W-1:0];
        quo_d = {quo_q[ADDR_W-2:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          job_d.page   = quo_d[PNUM_W-1:0];
          job_d.inpage = rem_d;
          state_d      = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= F_IDLE;
      page_size_q   <= '0;
      packet_size_q <= PKT_MIN;
      cnt_q         <= '0;
    end else begin
      state_q       <= state_d;
      page_size_q   <= page_size_d;
      packet_size_q <= packet_size_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

endmodule
`default_nettype wire

### hdl/pgsplit_queue.sv
`default_nettype none
module pgsplit_queue import pgsplit_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire pgsplit_job_t wr_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output pgsplit_job_t      rd_data_o
);

  pgsplit_job_t mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

### hdl/pgsplit_back.sv
`default_nettype none
module pgsplit_back import pgsplit_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         empty_i,
  input  wire pgsplit_job_t job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [IDX_W-1:0]  out_idx_o,
  output logic [PNUM_W-1:0] out_page_o,
  output logic [ADDR_W-1:0] out_addr_o,
  output logic [OFF_W-1:0]  out_off_o,
  output logic [LEN_W-1:0]  out_len_o,
  output logic              out_last_o,
  output logic              out_err_o
);

  logic         active_q, active_d;
  pgsplit_job_t cur_q, cur_d;
  logic [LEN_W-1:0] off_q, off_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  logic              ovalid_q, ovalid_d;
  logic [IDX_W-1:0]  oidx_q, oidx_d;
  logic [PNUM_W-1:0] opage_q, opage_d;
  logic [ADDR_W-1:0] oaddr_q, oaddr_d;
  logic [OFF_W-1:0]  ooff_q, ooff_d;
  logic [LEN_W-1:0]  olen_q, olen_d;
  logic              olast_q, olast_d;
  logic              oerr_q, oerr_d;

  logic              load, adv;
  logic [LEN_W-1:0]  rem_len, len0, len, end_off;
  logic [PAGE_W-1:0] room;
  logic              last;
  logic [ADDR_W:0]   addr_sum;
  logic [PAGE_W:0]   in_sum;

  always_comb begin
    load     = !active_q && !empty_i;
    adv      = active_q && (!ovalid_q || out_ready_i);
    rem_len  = cur_q.total - off_q;
    len0     = (rem_len > cur_q.pkt) ? cur_q.pkt : rem_len;
    room     = cur_q.pg - cur_q.inpage;
    len      = (cur_q.paged && ({5'd0, len0} > room)) ? room[LEN_W-1:0] : len0;
    end_off  = off_q + len;
    last     = (end_off >= cur_q.total) || (idx_q == IDX_LAST);
    addr_sum = {1'b0, cur_q.addr} + {21'd0, len};
    in_sum   = {1'b0, cur_q.inpage} + {6'd0, len};
  end

  assign pop_o = load;

  always_comb begin
    active_d = active_q;
    cur_d    = cur_q;
    off_d    = off_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oidx_d   = oidx_q;
    opage_d  = opage_q;
    oaddr_d  = oaddr_q;
    ooff_d   = ooff_q;
    olen_d   = olen_q;
    olast_d  = olast_q;
    oerr_d   = oerr_q;

    if (load) begin
      active_d = 1'b1;
      cur_d    = job_i;
      off_d    = '0;
      idx_d    = '0;
    end else if (adv) begin
      ovalid_d = 1'b1;
      if (cur_q.err) begin
        active_d = 1'b0;
        oidx_d   = '0;
        opage_d  = '0;
        oaddr_d  = '0;
        ooff_d   = '0;
        olen_d   = '0;
        olast_d  = 1'b0;
        oerr_d   = 1'b1;
      end else begin
        active_d = !last;
        oidx_d   = idx_q;
        opage_d  = cur_q.page;
        oaddr_d  = cur_q.paged ? {15'd0, cur_q.inpage} : cur_q.addr;
        ooff_d   = off_q[OFF_W-1:0];
        olen_d   = len;
        olast_d  = last;
        oerr_d   = 1'b0;
        off_d    = end_off;
        idx_d    = idx_q + 6'd1;
        cur_d.addr = addr_sum[ADDR_W-1:0];
        if (cur_q.paged) begin
          if (addr_sum[ADDR_W]) begin
            cur_d.page   = '0;
            cur_d.inpage = addr_sum[PAGE_W-1:0];
          end else if (in_sum == {1'b0, cur_q.pg}) begin
            cur_d.page   = cur_q.page + 25'd1;
            cur_d.inpage = '0;
          end else begin
            cur_d.inpage = in_sum[PAGE_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    off_q   <= off_d;
    idx_q   <= idx_d;
    oidx_q  <= oidx_d;
    opage_q <= opage_d;
    oaddr_q <= oaddr_d;
    ooff_q  <= ooff_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_idx_o   = oidx_q;
  assign out_page_o  = opage_q;
  assign out_addr_o  = oaddr_q;
  assign out_off_o   = ooff_q;
  assign out_len_o   = olen_q;
  assign out_last_o  = olast_q;
  assign out_err_o   = oerr_q;

endmodule
`default_nettype wire

### hdl/pgsplit_checker.sv
`default_nettype none
`include "page_aware_packet_splitter_defines.svh"
module pgsplit_checker import pgsplit_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic                  m_axis_tlast_o,
  input wire logic                  m_axis_tuser_o
);

  logic                  stalled;
  logic                  err_word;
  logic                  pkt_word;
  logic [LEN_W-1:0]      pkt_len;
  logic [OUT_DATA_W+1:0] word;

  assign stalled  = m_axis_tvalid_o && !m_axis_tready_i;
  assign err_word = m_axis_tvalid_o && m_axis_tuser_o;
  assign pkt_word = m_axis_tvalid_o && !m_axis_tuser_o;
  assign pkt_len  = m_axis_tdata_o[85:74];
  assign word     = {m_axis_tuser_o, m_axis_tlast_o, m_axis_tdata_o};

  `PGSPLIT_ASSERT_NXT(a_out_hold, stalled, m_axis_tvalid_o && $stable(word), "held word changed")
  `PGSPLIT_ASSERT_IMP(a_err_word, err_word, word[OUT_DATA_W:0] == '0, "error word has payload")
  `PGSPLIT_ASSERT_IMP(a_len_nonzero, pkt_word, pkt_len != '0, "empty packet")
  `PGSPLIT_ASSERT_IMP(a_len_max, pkt_word, pkt_len <= PKT_MAX, "packet above largest size")

endmodule

bind page_aware_packet_splitter pgsplit_checker u_pgsplit_checker (.*);
`default_nettype wire
